// ===== rtl/core/gsg_pkg.sv =====
// shared types, constants and control bundles of the gold sequence generator
`default_nettype none

package gsg_pkg;

    localparam int MAX_WORDS    = 64;
    localparam int WARMUP       = 1600;
    localparam int REG_W        = 31;
    localparam int LEN_W        = 12;
    localparam int WORD_W       = 32;
    localparam int MAX_BITS     = MAX_WORDS * WORD_W;
    localparam int WARM_STEPS32 = WARMUP / WORD_W;
    localparam int WARM_REM     = WARMUP % WORD_W;
    localparam int CNT_W        = 8;

    typedef struct packed {
        logic [REG_W-1:0] seed;
        logic [LEN_W-1:0] length;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic step32;
        logic step1;
        logic emit;
    } gsg_cmd_t;

    typedef struct packed {
        logic left_zero;
        logic last_word;
        logic out_free;
    } gsg_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/gsg_datapath.sv =====
// lfsr pair, bit counter and output register of the gold sequence generator
`default_nettype none

module gsg_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gsg_pkg::req_t       req,
    input  wire gsg_pkg::gsg_cmd_t   cmd,
    output gsg_pkg::gsg_status_t     status,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output gsg_pkg::rsp_t            rsp
);
    import gsg_pkg::*;

    localparam int EXT_W = REG_W + WORD_W;

    // 32 steps at once: bits 31..58 come from the old register, 59..62 from those
    function automatic logic [EXT_W-1:0] x1_ext(input logic [REG_W-1:0] a);
        logic [EXT_W-1:0] e;
        begin
            e = '0;
            e[REG_W-1:0] = a;
            for (int k = REG_W; k < 2 * REG_W - 3; k++)
            begin
                e[k] = e[k-28] ^ e[k-31];
            end
            for (int k = 2 * REG_W - 3; k < EXT_W; k++)
            begin
                e[k] = e[k-28] ^ e[k-31];
            end
            return e;
        end
    endfunction

    function automatic logic [EXT_W-1:0] x2_ext(input logic [REG_W-1:0] a);
        logic [EXT_W-1:0] e;
        begin
            e = '0;
            e[REG_W-1:0] = a;
            for (int k = REG_W; k < 2 * REG_W - 3; k++)
            begin
                e[k] = e[k-28] ^ e[k-29] ^ e[k-30] ^ e[k-31];
            end
            for (int k = 2 * REG_W - 3; k < EXT_W; k++)
            begin
                e[k] = e[k-28] ^ e[k-29] ^ e[k-30] ^ e[k-31];
            end
            return e;
        end
    endfunction

    logic [REG_W-1:0]  x1_reg, x1_next;
    logic [REG_W-1:0]  x2_reg, x2_next;
    logic [LEN_W-1:0]  left_reg, left_next;
    logic              valid_reg, valid_next;
    rsp_t              rsp_reg, rsp_next;
    logic [EXT_W-1:0]  e1, e2;
    logic [WORD_W-1:0] bits, mask;
    logic              full_word;

    assign e1 = x1_ext(x1_reg);
    assign e2 = x2_ext(x2_reg);
    assign bits = e1[WORD_W-1:0] ^ e2[WORD_W-1:0];
    assign full_word = left_reg >= LEN_W'(WORD_W);
    assign mask = full_word ? '1 : ~({WORD_W{1'b1}} << left_reg[4:0]);

    assign status.left_zero = left_reg == '0;
    assign status.last_word = left_reg <= LEN_W'(WORD_W);
    assign status.out_free  = !valid_reg || !rsp_stall;

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        x1_next    = x1_reg;
        x2_next    = x2_reg;
        left_next  = left_reg;
        valid_next = valid_reg && rsp_stall;
        rsp_next   = rsp_reg;
        if (cmd.load)
        begin
            x1_next = REG_W'(1);
            x2_next = req.seed;
            if (req.length > LEN_W'(MAX_BITS))
            begin
                left_next = LEN_W'(MAX_BITS);
            end
            else
            begin
                left_next = req.length;
            end
        end
        else if (cmd.step32)
        begin
            x1_next = e1[EXT_W-1:WORD_W];
            x2_next = e2[EXT_W-1:WORD_W];
        end
        else if (cmd.step1)
        begin
            x1_next = {x1_reg[3] ^ x1_reg[0], x1_reg[REG_W-1:1]};
            x2_next = {x2_reg[3] ^ x2_reg[2] ^ x2_reg[1] ^ x2_reg[0], x2_reg[REG_W-1:1]};
        end
        if (cmd.emit)
        begin
            valid_next    = 1'b1;
            rsp_next.word = bits & mask;
            rsp_next.last = !full_word || left_reg == LEN_W'(WORD_W);
            left_next     = full_word ? left_reg - LEN_W'(WORD_W) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg    <= '0;
            x2_reg    <= '0;
            left_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            x1_reg    <= x1_next;
            x2_reg    <= x2_next;
            left_reg  <= left_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/gsg_control.sv =====
// sequencing state machine of the gold sequence generator
`default_nettype none

module gsg_control (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire gsg_pkg::gsg_status_t status,
    output gsg_pkg::gsg_cmd_t         cmd
);
    import gsg_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WARM32 = 2'd1;
    localparam logic [1:0] S_WARM1  = 2'd2;
    localparam logic [1:0] S_RUN    = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign req_stall = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (WARM_STEPS32 != 0)
                    begin
                        state_next = S_WARM32;
                        cnt_next   = CNT_W'(WARM_STEPS32);
                    end
                    else if (WARM_REM != 0)
                    begin
                        state_next = S_WARM1;
                        cnt_next   = CNT_W'(WARM_REM);
                    end
                    else
                    begin
                        state_next = S_RUN;
                    end
                end
            end
            S_WARM32:
            begin
                cmd.step32 = 1'b1;
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    if (WARM_REM != 0)
                    begin
                        state_next = S_WARM1;
                        cnt_next   = CNT_W'(WARM_REM);
                    end
                    else
                    begin
                        state_next = S_RUN;
                    end
                end
            end
            S_WARM1:
            begin
                cmd.step1 = 1'b1;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (status.left_zero)
                begin
                    state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.step32 = 1'b1;
                    if (status.last_word)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/gold_sequence_generator.sv =====
// top level of the length-31 gold sequence generator
//
//   channel | dir | handshake           | payload
//   req     | in  | req_valid/req_stall | seed, length
//   rsp     | out | rsp_valid/rsp_stall | word, last
//
// one transfer in, then a warm-up of 1600 lfsr steps, taken 32 at a time
// then one word per cycle into the output register while the output is not
// stalled; the lfsr pair advances 32 steps per cycle during warm-up and word output
// a stalled output holds the word generator; the next request is taken once
// the final word sits in the output register
// reset clears the state machine, the lfsrs and the output valid
`default_nettype none

module gold_sequence_generator (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire gsg_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output gsg_pkg::rsp_t      rsp
);
    import gsg_pkg::*;

    gsg_cmd_t    cmd;
    gsg_status_t status;

    gsg_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    gsg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== test/gold_sequence_generator_tb.sv =====
// self-checking testbench of the gold sequence generator with a word-level predictor

`default_nettype none

module gold_sequence_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import gsg_pkg::*;

    localparam int RANDOM_ITEMS = 380;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 200;

    class gold_word_ledger;
        rsp_t pending_words[$];
        int   mismatches;

        function new();
            mismatches = 0;
        endfunction

        // advance both sequence registers by one step
        static function void step_pair(ref logic [REG_W-1:0] x1, ref logic [REG_W-1:0] x2);
            logic fb1;
            logic fb2;
            fb1 = x1[3] ^ x1[0];
            fb2 = x2[3] ^ x2[2] ^ x2[1] ^ x2[0];
            x1  = {fb1, x1[REG_W-1:1]};
            x2  = {fb2, x2[REG_W-1:1]};
        endfunction

        function void note_request(req_t item);
            logic [REG_W-1:0]  x1;
            logic [REG_W-1:0]  x2;
            logic [WORD_W-1:0] acc;
            int unsigned       n_bits;
            int unsigned       n_words;
            int unsigned       done;
            rsp_t              entry;
            x1     = REG_W'(1);
            x2     = item.seed;
            n_bits = 32'(item.length);
            if (n_bits > MAX_BITS)
            begin
                n_bits = MAX_BITS;
            end
            repeat (WARMUP) step_pair(x1, x2);
            n_words = (n_bits + 31) / 32;
            done    = 0;
            for (int unsigned w = 0; w < n_words; w++)
            begin
                acc = '0;
                for (int b = 0; b < WORD_W && done < n_bits; b++)
                begin
                    acc[b] = x1[0] ^ x2[0];
                    step_pair(x1, x2);
                    done++;
                end
                entry.word = acc;
                entry.last = (w + 1 == n_words);
                pending_words.push_back(entry);
            end
        endfunction

        function void check_word(rsp_t got);
            rsp_t want;
            if (pending_words.size() == 0)
            begin
                $error("unexpected word %h (last %b) with nothing pending", got.word, got.last);
                mismatches++;
                return;
            end
            want = pending_words.pop_front();
            if (got.word !== want.word)
            begin
                $error("word: expected %h, got %h", want.word, got.word);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %b, got %b", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    gold_word_ledger board;
    bit              calm;
    int              cycle_count;

    gold_sequence_generator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic req_t make_req(logic [REG_W-1:0] s, logic [LEN_W-1:0] l);
        req_t item;
        item.seed   = s;
        item.length = l;
        return item;
    endfunction

    task automatic send_request(input req_t item);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (req_stall);
        board.note_request(item);
    endtask

    task automatic wait_for_drain();
        req_valid <= 1'b0;
        while (board.pending_words.size() != 0) @(posedge clk);
    endtask

    // output side stall pattern, one draw per word transfer
    initial
    begin
        int unsigned hold;
        @(posedge rst_n);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 13);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            board.check_word(rsp);
        end
    end

    initial
    begin
        logic [REG_W-1:0] s;
        logic [LEN_W-1:0] l;
        int unsigned      pick;
        board     = new();
        calm      = 1'b0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        rsp_stall <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, word boundaries, zero length, clamping
        send_request(make_req(31'h0000_0000, 12'd1));
        send_request(make_req(31'h7FFF_FFFF, 12'd2048));
        send_request(make_req(31'h0000_0001, 12'd32));
        send_request(make_req(31'h4000_0000, 12'd33));
        send_request(make_req(31'h5555_5555, 12'd31));
        send_request(make_req(31'h2AAA_AAAA, 12'd63));
        send_request(make_req(31'h1234_5678, 12'd64));
        send_request(make_req(31'h0000_0000, 12'd0));
        send_request(make_req(31'h0BAD_CAFE, 12'd17));
        send_request(make_req(31'h7FFF_FFFF, 12'd4095));
        send_request(make_req(31'h0000_0001, 12'd2049));
        send_request(make_req(31'h3C3C_3C3C, 12'd2047));
        send_request(make_req(31'h0F0F_0F0F, 12'd1024));
        send_request(make_req(31'h7FFF_FFFE, 12'd100));
        send_request(make_req(31'h0000_0000, 12'd2048));
        send_request(make_req(31'h6DB6_DB6D, 12'd1));
        wait_for_drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = ((i / 40) % 3 == 1);
            pick = $urandom_range(0, 9);
            case (pick)
                0:       s = '0;
                1:       s = '1;
                2:       s = 31'h1 << $urandom_range(0, REG_W - 1);
                default: s = REG_W'($urandom());
            endcase
            pick = $urandom_range(0, 9);
            if (pick < 7)
                l = LEN_W'($urandom_range(1, 96));
            else if (pick < 9)
                l = LEN_W'($urandom_range(97, 1024));
            else
                l = LEN_W'($urandom_range(1025, 2048));
            send_request(make_req(s, l));
            if (i == RANDOM_ITEMS / 2)
            begin
                wait_for_drain();
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/gsg_pkg.sv
rtl/core/gsg_datapath.sv
rtl/core/gsg_control.sv
rtl/core/gold_sequence_generator.sv
test/gold_sequence_generator_tb.sv
